// ===== src/pzt_pkg.sv =====
package pzt_pkg;

   // Width used for all row arithmetic, wide enough for the default 21-bit row width plus margin.
   localparam int CALC_W = 34;

   // Retention register limits and reset value.
   localparam int RET_W = 20;
   localparam logic [RET_W-1:0] RET_MIN = 20'd1;
   localparam logic [RET_W-1:0] RET_MAX = 20'd1000000;
   localparam logic [RET_W-1:0] RET_RESET = 20'd10000;

   // Field widths of the transfers.
   localparam int KIND_W = 3;
   localparam int CUR_W = 10;
   localparam int VOFF_W = 20;
   localparam int TARGET_W = 21;
   localparam int COUNT_W = 9;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_PROMPT = 3'd0;
   localparam logic [KIND_W-1:0] KIND_DONE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_SCROLL = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NAV_UP = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NAV_DOWN = 3'd4;
   localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd5;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd6;

   // Sequencer states.
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_NAGE   = 8'b0000_0010,
      ST_NSTART = 8'b0000_0100,
      ST_RD     = 8'b0000_1000,
      ST_AP     = 8'b0001_0000,
      ST_AE     = 8'b0010_0000,
      ST_CMP    = 8'b0100_0000,
      ST_DONE   = 8'b1000_0000
   } state_type;

   // Flags from the shared row unit.
   typedef struct packed {
      logic lt_negr;
      logic lt_start;
      logic gt_start;
   } row_flags_type;

endpackage

// ===== src/pzt_store.sv =====
module pzt_store #(
   parameter int DEPTH = 256,
   parameter int AW = 8,
   parameter int RW = 21
) (
   input  logic                 clock,
   input  logic [AW-1:0]        rd_addr,
   output logic signed [RW-1:0] rd_prompt,
   output logic signed [RW-1:0] rd_end,
   output logic                 rd_known,
   input  logic [AW-1:0]        wr_addr,
   input  logic                 prompt_we,
   input  logic signed [RW-1:0] wr_prompt,
   input  logic                 end_we,
   input  logic signed [RW-1:0] wr_end,
   input  logic                 wr_known
);

   logic signed [RW-1:0] prompt_mem [DEPTH];
   logic [RW:0]          end_mem [DEPTH];
   logic [RW:0]          end_rd_ff;

   // Prompt row memory, one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (prompt_we) begin
         prompt_mem[wr_addr] <= wr_prompt;
      end
      rd_prompt <= prompt_mem[rd_addr];
   end

   // End row memory with its known flag in the top bit.
   always_ff @(posedge clock) begin
      if (end_we) begin
         end_mem[wr_addr] <= {wr_known, wr_end};
      end
      end_rd_ff <= end_mem[rd_addr];
   end

   assign rd_known = end_rd_ff[RW];
   assign rd_end = $signed(end_rd_ff[RW-1:0]);

endmodule

// ===== src/pzt_row_unit.sv =====
module pzt_row_unit #(
   parameter int RW = 21
) (
   input  logic signed [pzt_pkg::CALC_W-1:0] value,
   input  logic                              age,
   input  logic signed [pzt_pkg::CALC_W-1:0] negr,
   input  logic signed [pzt_pkg::CALC_W-1:0] start,
   output logic signed [RW-1:0]              result,
   output pzt_pkg::row_flags_type            flags
);

   localparam logic signed [pzt_pkg::CALC_W-1:0] ROW_HI =
      pzt_pkg::CALC_W'((64'sd1 <<< (RW - 1)) - 64'sd1);
   localparam logic signed [pzt_pkg::CALC_W-1:0] ROW_LO = -ROW_HI - 1;

   logic signed [pzt_pkg::CALC_W-1:0] step;
   logic signed [pzt_pkg::CALC_W-1:0] floor_row;
   logic signed [pzt_pkg::CALC_W-1:0] clamped;

   // When age is set, age by one row against the floor; then saturate to the row range.
   always_comb begin
      floor_row = negr - 1;
      step = age ? value - 1 : value;
      if (age && step < floor_row) begin
         step = floor_row;
      end
      clamped = step;
      if (step > ROW_HI) begin
         clamped = ROW_HI;
      end else if (step < ROW_LO) begin
         clamped = ROW_LO;
      end
   end

   assign result = clamped[RW-1:0];
   assign flags.lt_negr = clamped < negr;
   assign flags.lt_start = clamped < start;
   assign flags.gt_start = clamped > start;

endmodule

// ===== src/prompt_zone_table_tracker.sv =====
// Prompt, done, cancel and clear events go straight to the result. Navigation passes through
// NSTART, then RD and CMP for each held zone; a scroll tick passes NAGE, then RD, AP and AE for each.
// Throughput: one event at a time; the next is taken once the result is loaded.
// A scroll tick or navigation walks every held zone through one shared row unit
// and the single read port of the zone memories.
// Reset (synchronous) empties the table, forgets the navigation row and sets retention to 10000.
module prompt_zone_table_tracker #(
   parameter int ZONE_DEPTH = 256,
   parameter int ROW_BITS = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // kind[2:0], cursor_row[12:3], view_offset[32:13]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // found[0], hit_row[21:1], zone_count[30:22]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_data     // retention
);

   localparam int AW = $clog2(ZONE_DEPTH);
   localparam int CW = $clog2(ZONE_DEPTH + 1);
   localparam int CALC_W = pzt_pkg::CALC_W;
   localparam logic [AW:0] DEPTH_S = (AW + 1)'(ZONE_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(ZONE_DEPTH - 1);

   pzt_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                   head_ff, head_in;
   logic [CW-1:0]                   count_ff, count_in;
   logic signed [ROW_BITS-1:0]      nav_row_ff, nav_row_in;
   logic                            nav_known_ff, nav_known_in;
   logic [pzt_pkg::RET_W-1:0]       ret_ff, ret_in;
   logic [pzt_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [pzt_pkg::CUR_W-1:0]       cur_ff, cur_in;
   logic [pzt_pkg::VOFF_W-1:0]      voff_ff, voff_in;
   logic [AW-1:0]                   rptr_ff, rptr_in;
   logic [AW-1:0]                   wptr_ff, wptr_in;
   logic [CW-1:0]                   rem_ff, rem_in;
   logic [CW-1:0]                   kept_ff, kept_in;
   logic                            newer_ff, newer_in;
   logic                            newer_exp_ff, newer_exp_in;
   logic signed [ROW_BITS-1:0]      p_aged_ff, p_aged_in;
   logic                            p_exp_ff, p_exp_in;
   logic signed [CALC_W-1:0]        start_ff, start_in;
   logic                            found_ff, found_in;
   logic signed [ROW_BITS-1:0]      target_ff, target_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [31:0]                     rsp_data_ff, rsp_data_in;

   // Zone memory signals.
   logic signed [ROW_BITS-1:0] rd_prompt, rd_end, wr_prompt, wr_end;
   logic                       rd_known, wr_known, prompt_we, end_we;
   logic [AW-1:0]              wr_addr;

   // Shared row unit signals.
   logic signed [CALC_W-1:0]   unit_value, negr;
   logic                       unit_age;
   logic signed [ROW_BITS-1:0] unit_result;
   pzt_pkg::row_flags_type     unit_flags;

   logic                       req_fire;
   logic [pzt_pkg::KIND_W-1:0] req_kind;
   logic [pzt_pkg::CUR_W-1:0]  req_cur;
   logic [pzt_pkg::VOFF_W-1:0] req_voff;
   logic [AW-1:0]              tail_idx, newest_idx, wptr_dec, rptr_inc, rptr_dec;
   logic [AW:0]                tail_sum;
   logic [AW:0]                newest_sum;
   logic [AW-1:0]              head_after;
   logic                       gone;
   logic signed [CALC_W-1:0]   target_ext;
   logic [CW-1:0]              kept_next;
   logic [AW:0]                wptr_inc_sum;

   function automatic logic [AW-1:0] wrap_idx(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= DEPTH_S) ? s - DEPTH_S : s;
      return r[AW-1:0];
   endfunction

   assign req_kind = req_tdata[2:0];
   assign req_cur = req_tdata[12:3];
   assign req_voff = req_tdata[32:13];

   assign req_tready = (state_ff == pzt_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   // Ring buffer positions.
   assign tail_sum = (AW + 1)'(head_ff) + (AW + 1)'(count_ff);
   assign tail_idx = wrap_idx(tail_sum);
   assign newest_sum = (tail_sum == '0) ? DEPTH_S - 1'b1 : tail_sum - 1'b1;
   assign newest_idx = wrap_idx(newest_sum);
   assign wptr_dec = (wptr_ff == '0) ? LAST_IDX : wptr_ff - 1'b1;
   assign rptr_dec = (rptr_ff == '0) ? LAST_IDX : rptr_ff - 1'b1;
   assign rptr_inc = (rptr_ff == LAST_IDX) ? '0 : rptr_ff + 1'b1;
   assign wptr_inc_sum = (AW + 1)'(wptr_dec) + 1'b1;
   assign head_after = wrap_idx(wptr_inc_sum);

   assign negr = -$signed(CALC_W'(ret_ff));
   assign target_ext = CALC_W'(target_ff);

   // Removal decision for the zone under examination in a scroll pass.
   assign gone = rd_known ? unit_flags.lt_negr : (newer_ff && newer_exp_ff);
   assign kept_next = gone ? kept_ff : kept_ff + 1'b1;

   // Operand selection for the shared row unit.
   always_comb begin
      unit_value = CALC_W'(rd_prompt);
      unit_age = 1'b0;
      unique case (state_ff)
         pzt_pkg::ST_NAGE: begin
            unit_value = CALC_W'(nav_row_ff);
            unit_age = 1'b1;
         end
         pzt_pkg::ST_NSTART: begin
            if (nav_known_ff) begin
               unit_value = CALC_W'(nav_row_ff);
            end else if (voff_ff != '0) begin
               unit_value = -$signed(CALC_W'(voff_ff));
            end else begin
               unit_value = $signed(CALC_W'(cur_ff)) + 1;
            end
         end
         pzt_pkg::ST_AP: begin
            unit_age = 1'b1;
         end
         pzt_pkg::ST_AE: begin
            unit_value = CALC_W'(rd_end);
            unit_age = 1'b1;
         end
         default: begin
            unit_value = CALC_W'(rd_prompt);
         end
      endcase
   end

   pzt_row_unit #(
      .RW(ROW_BITS)
   ) u_row_unit (
      .value  (unit_value),
      .age    (unit_age),
      .negr   (negr),
      .start  (start_ff),
      .result (unit_result),
      .flags  (unit_flags)
   );

   pzt_store #(
      .DEPTH(ZONE_DEPTH),
      .AW(AW),
      .RW(ROW_BITS)
   ) u_store (
      .clock     (clock),
      .rd_addr   (rptr_ff),
      .rd_prompt (rd_prompt),
      .rd_end    (rd_end),
      .rd_known  (rd_known),
      .wr_addr   (wr_addr),
      .prompt_we (prompt_we),
      .wr_prompt (wr_prompt),
      .end_we    (end_we),
      .wr_end    (wr_end),
      .wr_known  (wr_known)
   );

   // Memory writes: new zones, closed zones and survivors of a scroll pass.
   always_comb begin
      wr_addr = wptr_ff;
      prompt_we = 1'b0;
      end_we = 1'b0;
      wr_prompt = p_aged_ff;
      wr_end = rd_known ? unit_result : rd_end;
      wr_known = rd_known;
      if (req_fire && req_kind == pzt_pkg::KIND_PROMPT) begin
         wr_addr = tail_idx;
         prompt_we = 1'b1;
         end_we = 1'b1;
         wr_prompt = ROW_BITS'(req_cur);
         wr_end = '0;
         wr_known = 1'b0;
      end else if (req_fire && req_kind == pzt_pkg::KIND_DONE) begin
         wr_addr = newest_idx;
         end_we = (count_ff != '0);
         wr_end = ROW_BITS'(req_cur);
         wr_known = 1'b1;
      end else if (state_ff == pzt_pkg::ST_AE && !gone) begin
         prompt_we = 1'b1;
         end_we = 1'b1;
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      head_in = head_ff;
      count_in = count_ff;
      nav_row_in = nav_row_ff;
      nav_known_in = nav_known_ff;
      ret_in = ret_ff;
      kind_in = kind_ff;
      cur_in = cur_ff;
      voff_in = voff_ff;
      rptr_in = rptr_ff;
      wptr_in = wptr_ff;
      rem_in = rem_ff;
      kept_in = kept_ff;
      newer_in = newer_ff;
      newer_exp_in = newer_exp_ff;
      p_aged_in = p_aged_ff;
      p_exp_in = p_exp_ff;
      start_in = start_ff;
      found_in = found_ff;
      target_in = target_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      // Retention write, clamped to its legal range.
      if (csr_valid) begin
         if (csr_data < pzt_pkg::RET_MIN) begin
            ret_in = pzt_pkg::RET_MIN;
         end else if (csr_data > pzt_pkg::RET_MAX) begin
            ret_in = pzt_pkg::RET_MAX;
         end else begin
            ret_in = csr_data;
         end
      end

      unique case (state_ff)
         pzt_pkg::ST_IDLE: begin
            if (req_fire) begin
               kind_in = req_kind;
               cur_in = req_cur;
               voff_in = req_voff;
               found_in = 1'b0;
               target_in = '0;
               rem_in = count_ff;
               kept_in = '0;
               newer_in = 1'b0;
               newer_exp_in = 1'b0;
               state_in = pzt_pkg::ST_DONE;
               unique case (req_kind)
                  pzt_pkg::KIND_PROMPT: begin
                     if (count_ff == CW'(ZONE_DEPTH)) begin
                        head_in = (head_ff == LAST_IDX) ? '0 : head_ff + 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  pzt_pkg::KIND_SCROLL: begin
                     rptr_in = newest_idx;
                     wptr_in = newest_idx;
                     state_in = pzt_pkg::ST_NAGE;
                  end
                  pzt_pkg::KIND_NAV_UP, pzt_pkg::KIND_NAV_DOWN: begin
                     rptr_in = head_ff;
                     state_in = pzt_pkg::ST_NSTART;
                  end
                  pzt_pkg::KIND_CANCEL: begin
                     nav_known_in = 1'b0;
                  end
                  pzt_pkg::KIND_CLEAR: begin
                     count_in = '0;
                     nav_known_in = 1'b0;
                  end
                  default: begin
                     state_in = pzt_pkg::ST_DONE;
                  end
               endcase
            end
         end
         pzt_pkg::ST_NAGE: begin
            if (nav_known_ff) begin
               nav_row_in = unit_result;
            end
            state_in = (rem_ff == '0) ? pzt_pkg::ST_DONE : pzt_pkg::ST_RD;
         end
         pzt_pkg::ST_NSTART: begin
            start_in = CALC_W'(unit_result);
            state_in = (rem_ff == '0) ? pzt_pkg::ST_DONE : pzt_pkg::ST_RD;
         end
         pzt_pkg::ST_RD: begin
            state_in = (kind_ff == pzt_pkg::KIND_SCROLL) ? pzt_pkg::ST_AP : pzt_pkg::ST_CMP;
         end
         pzt_pkg::ST_CMP: begin
            if (kind_ff == pzt_pkg::KIND_NAV_UP) begin
               if (unit_flags.lt_start && !unit_flags.lt_negr) begin
                  found_in = 1'b1;
                  target_in = unit_result;
               end
            end else if (unit_flags.gt_start && !found_ff) begin
               found_in = 1'b1;
               target_in = unit_result;
            end
            rem_in = rem_ff - 1'b1;
            rptr_in = rptr_inc;
            state_in = (rem_ff == CW'(1)) ? pzt_pkg::ST_DONE : pzt_pkg::ST_RD;
         end
         pzt_pkg::ST_AP: begin
            p_aged_in = unit_result;
            p_exp_in = unit_flags.lt_negr;
            state_in = pzt_pkg::ST_AE;
         end
         pzt_pkg::ST_AE: begin
            if (!gone) begin
               wptr_in = wptr_dec;
               kept_in = kept_next;
               newer_in = 1'b1;
               newer_exp_in = p_exp_ff;
            end
            rem_in = rem_ff - 1'b1;
            rptr_in = rptr_dec;
            if (rem_ff == CW'(1)) begin
               count_in = kept_next;
               if (kept_next != '0) begin
                  head_in = gone ? wrap_idx((AW + 1)'(wptr_ff) + 1'b1) : head_after;
               end
               state_in = pzt_pkg::ST_DONE;
            end else begin
               state_in = pzt_pkg::ST_RD;
            end
         end
         pzt_pkg::ST_DONE: begin
            // Load the result once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {1'b0, pzt_pkg::COUNT_W'(count_ff),
                              found_ff ? target_ext[pzt_pkg::TARGET_W-1:0] : 21'd0,
                              found_ff};
               if (found_ff) begin
                  nav_row_in = target_ff;
                  nav_known_in = 1'b1;
               end
               state_in = pzt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pzt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pzt_pkg::ST_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         nav_row_ff <= '0;
         nav_known_ff <= 1'b0;
         ret_ff <= pzt_pkg::RET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         nav_row_ff <= nav_row_in;
         nav_known_ff <= nav_known_in;
         ret_ff <= ret_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers of the current event.
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      cur_ff <= cur_in;
      voff_ff <= voff_in;
      rptr_ff <= rptr_in;
      wptr_ff <= wptr_in;
      rem_ff <= rem_in;
      kept_ff <= kept_in;
      newer_ff <= newer_in;
      newer_exp_ff <= newer_exp_in;
      p_aged_ff <= p_aged_in;
      p_exp_ff <= p_exp_in;
      start_ff <= start_in;
      found_ff <= found_in;
      target_ff <= target_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
